// ===== hw/rtl/detection_marker_tracker_defines.svh =====
// Assertion macros for the marker tracker
`ifndef DETECTION_MARKER_TRACKER_DEFINES_SVH
`define DETECTION_MARKER_TRACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DMT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("marker tracker assertion failed");
`define DMT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("marker tracker assertion failed");
`else
`define DMT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define DMT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/dmt_pkg.sv =====
// Shared constants and types for the marker tracker
package dmt_pkg;

    localparam int MARKER_SLOTS_DEF = 16;

    localparam int COORD_W    = 12;
    localparam int CENTER_W   = 13;
    localparam int RAD_W      = 12;
    localparam int LIFE_W     = 9;
    localparam int CNT_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int ID_W       = 5;
    localparam int FUNC_W     = 2;
    localparam int TOL_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 64;
    localparam int M_USED_W   = ID_W + 2 * CENTER_W + RAD_W + CNT_W;
    localparam int DIFF_W     = CENTER_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = 26;
    localparam int DIST_W     = SQ_W + 1;
    localparam int R2_W       = 2 * RAD_W;

    localparam logic [FUNC_W-1:0] FUNC_FSTART = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DET    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FEND   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_MATCH   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NEW     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SUMMARY = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [TOL_W-1:0]   TOL_RST    = 8'd5;
    localparam logic [TOL_W-1:0]   TOL_MIN    = 8'd2;
    localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd480;

    localparam logic signed [LIFE_W-1:0] LIFE_MIN = 9'sh100;
    localparam logic [ID_W-1:0]          ID_NONE  = 5'h1F;
    localparam logic [CNT_W-1:0]         CNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [CENTER_W-1:0]      x;
        logic [CENTER_W-1:0]      y;
        logic signed [LIFE_W-1:0] life;
    } slot_entry_t;

    localparam int SLOT_W = $bits(slot_entry_t);

endpackage

// ===== hw/rtl/dmt_ram.sv =====
// Simple dual-port RAM with registered read
module dmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/detection_marker_tracker.sv =====
// Marker tracker: slot table in RAM, one slot read per cycle, one request at a time
// Detection: PREP, then a SCAN of the slots that stops at the first match, WRITE and DONE,
// which loads the result once the output is free. Frame end scans every slot, then DONE
// loads the summary; frame start scans and ages every valid slot; clear empties the table.
// Slots are walked through the single RAM read port; the next request waits for idle.
// Synchronous active-low reset: config to defaults, all slots empty, count zero.
`include "detection_marker_tracker_defines.svh"

module detection_marker_tracker import dmt_pkg::*; #(
    parameter int MARKER_SLOTS = MARKER_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // rect_x[11:0], rect_y[23:12], rect_w[35:24], rect_h[47:36]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // marker_id[4:0], center_x[17:5], center_y[30:18], radius[42:31],
    // detection_count[58:43], zero[63:59]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0]   m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDXW = MARKER_SLOTS > 1 ? $clog2(MARKER_SLOTS) : 1;
    localparam int CNTW = $clog2(MARKER_SLOTS + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MARKER_SLOTS - 1);
    localparam logic [CNTW-1:0] SLOT_CNT = CNTW'(MARKER_SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // control
    logic [2:0]              state_reg, state_next;
    logic [FUNC_W-1:0]       op_reg, op_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic                    p1_vld_reg, p1_vld_next;
    logic                    p2_vld_reg, p2_vld_next;
    logic                    match_reg, match_next;
    logic                    free_found_reg, free_found_next;
    logic [MARKER_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]        det_count_reg, det_count_next;
    logic [TOL_W-1:0]        tol_reg, tol_next;
    logic [COORD_W-1:0]      iw_reg, iw_next;
    logic [COORD_W-1:0]      ih_reg, ih_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // payload
    logic [CENTER_W-1:0]     cx_reg, cy_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [R2_W-1:0]         r2_reg;
    logic [IDXW-1:0]         p1_idx_reg, p2_idx_reg, match_idx_reg, free_idx_reg;
    logic                    p1_sv_reg, p2_sv_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [ID_W-1:0]         res_id_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    logic [ID_W-1:0]         m_id_reg;
    logic [CENTER_W-1:0]     m_cx_reg, m_cy_reg;
    logic [RAD_W-1:0]        m_rad_reg;
    logic [CNT_W-1:0]        m_cnt_reg;

    // input fields and rounding
    logic [COORD_W-1:0]  in_x, in_y, in_w, in_h;
    logic [DIFF_W-1:0]   sum_x, sum_y;
    logic [CENTER_W-1:0] half_x, half_y, cx_calc, cy_calc;
    logic [CENTER_W-1:0] wh_sum;
    logic [RAD_W-2:0]    quarter;
    logic                rad_up;
    logic [RAD_W-1:0]    rad_calc;

    // slot memory
    logic                wr_en, rd_en;
    logic [IDXW-1:0]     wr_addr, cnt_idx;
    slot_entry_t         wr_entry, rd_entry;
    logic [SLOT_W-1:0]   rd_data;

    // distance path
    logic signed [DIFF_W-1:0]    dx, dy;
    logic signed [PROD_W-1:0]    prod_x, prod_y;
    logic signed [LIFE_W-1:0]    life_dec;
    logic [DIST_W-1:0]           dist_sq;
    logic                        hit, outside, issue, load_out;

    assign in_x = s_tdata[11:0];
    assign in_y = s_tdata[23:12];
    assign in_w = s_tdata[35:24];
    assign in_h = s_tdata[47:36];

    assign sum_x   = {1'b0, in_x, 1'b0} + DIFF_W'(in_w);
    assign sum_y   = {1'b0, in_y, 1'b0} + DIFF_W'(in_h);
    assign half_x  = sum_x[DIFF_W-1:1];
    assign half_y  = sum_y[DIFF_W-1:1];
    assign cx_calc = half_x + CENTER_W'(sum_x[0] & half_x[0]);
    assign cy_calc = half_y + CENTER_W'(sum_y[0] & half_y[0]);

    assign wh_sum   = CENTER_W'(in_w) + CENTER_W'(in_h);
    assign quarter  = wh_sum[CENTER_W-1:2];
    assign rad_up   = (wh_sum[1:0] == 2'd3) || (wh_sum[1:0] == 2'd2 && quarter[0]);
    assign rad_calc = {1'b0, quarter} + RAD_W'(rad_up);

    assign cnt_idx  = cnt_reg[IDXW-1:0];
    assign issue    = (state_reg == S_SCAN) && (cnt_reg < SLOT_CNT);
    assign rd_en    = issue;
    assign rd_entry = slot_entry_t'(rd_data);

    assign dx       = $signed({1'b0, cx_reg}) - $signed({1'b0, rd_entry.x});
    assign dy       = $signed({1'b0, cy_reg}) - $signed({1'b0, rd_entry.y});
    assign prod_x   = dx * dx;
    assign prod_y   = dy * dy;
    assign life_dec = (rd_entry.life == LIFE_MIN) ? rd_entry.life : rd_entry.life - 9'sd1;

    assign dist_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign hit     = p2_vld_reg && p2_sv_reg && (dist_sq <= DIST_W'(r2_reg));
    assign outside = ({1'b0, iw_reg} < cx_reg) || ({1'b0, ih_reg} < cy_reg);

    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (state_reg == S_WRITE) begin
            wr_en         = match_reg || (!outside && free_found_reg);
            wr_addr       = match_reg ? match_idx_reg : free_idx_reg;
            wr_entry.x    = cx_reg;
            wr_entry.y    = cy_reg;
            wr_entry.life = $signed({1'b0, tol_reg});
        end else begin
            wr_en         = (state_reg == S_SCAN) && (op_reg == FUNC_FSTART) &&
                            p1_vld_reg && p1_sv_reg;
            wr_addr       = p1_idx_reg;
            wr_entry.x    = rd_entry.x;
            wr_entry.y    = rd_entry.y;
            wr_entry.life = life_dec;
        end
    end

    dmt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MARKER_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (cnt_idx),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        p1_vld_next     = 1'b0;
        p2_vld_next     = 1'b0;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        valid_next      = valid_reg;
        det_count_next  = det_count_reg;
        tol_next        = tol_reg;
        iw_next         = iw_reg;
        ih_next         = ih_reg;
        m_tvalid_next   = m_tvalid_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TOL: begin
                    if (cfg_data[TOL_W-1:0] >= TOL_MIN) begin
                        tol_next = cfg_data[TOL_W-1:0];
                    end
                end
                CFG_WIDTH:  iw_next = cfg_data[COORD_W-1:0];
                CFG_HEIGHT: ih_next = cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    cnt_next        = '0;
                    match_next      = 1'b0;
                    free_found_next = 1'b0;
                    unique case (s_tuser)
                        FUNC_FSTART: begin
                            det_count_next = '0;
                            state_next     = S_SCAN;
                        end
                        FUNC_DET: begin
                            if (det_count_reg != CNT_MAX) begin
                                det_count_next = det_count_reg + 16'd1;
                            end
                            state_next = S_PREP;
                        end
                        FUNC_FEND:  state_next = S_SCAN;
                        FUNC_CLEAR: valid_next = '0;
                        default: ;
                    endcase
                end
            end
            S_PREP: state_next = S_SCAN;
            S_SCAN: begin
                if (issue) begin
                    cnt_next    = cnt_reg + 1'b1;
                    p1_vld_next = 1'b1;
                    if (!valid_reg[cnt_idx] && !free_found_reg) begin
                        free_found_next = 1'b1;
                    end
                end
                p2_vld_next = p1_vld_reg && (op_reg == FUNC_DET);
                if (op_reg == FUNC_FEND && p1_vld_reg && p1_sv_reg && rd_entry.life < 0) begin
                    valid_next[p1_idx_reg] = 1'b0;
                end
                if (op_reg == FUNC_DET) begin
                    if (hit) begin
                        match_next = 1'b1;
                        state_next = S_WRITE;
                    end else if (p2_vld_reg && p2_idx_reg == LAST_IDX) begin
                        state_next = S_WRITE;
                    end
                end else if (p1_vld_reg && p1_idx_reg == LAST_IDX) begin
                    state_next = (op_reg == FUNC_FEND) ? S_DONE : S_IDLE;
                end
            end
            S_WRITE: begin
                if (!match_reg && !outside && free_found_reg) begin
                    valid_next[free_idx_reg] = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            op_reg         <= FUNC_FSTART;
            cnt_reg        <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            det_count_reg  <= '0;
            tol_reg        <= TOL_RST;
            iw_reg         <= WIDTH_RST;
            ih_reg         <= HEIGHT_RST;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cnt_reg        <= cnt_next;
            p1_vld_reg     <= p1_vld_next;
            p2_vld_reg     <= p2_vld_next;
            match_reg      <= match_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            det_count_reg  <= det_count_next;
            tol_reg        <= tol_next;
            iw_reg         <= iw_next;
            ih_reg         <= ih_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            cx_reg  <= cx_calc;
            cy_reg  <= cy_calc;
            rad_reg <= rad_calc;
        end
        if (state_reg == S_PREP) begin
            r2_reg <= rad_reg * rad_reg;
        end
        if (issue) begin
            p1_idx_reg <= cnt_idx;
            p1_sv_reg  <= valid_reg[cnt_idx];
            if (!valid_reg[cnt_idx] && !free_found_reg) begin
                free_idx_reg <= cnt_idx;
            end
        end
        if (p1_vld_reg) begin
            p2_idx_reg <= p1_idx_reg;
            p2_sv_reg  <= p1_sv_reg;
            sqx_reg    <= prod_x[SQ_W-1:0];
            sqy_reg    <= prod_y[SQ_W-1:0];
        end
        if (state_reg == S_SCAN && hit) begin
            match_idx_reg <= p2_idx_reg;
        end
        if (state_reg == S_WRITE) begin
            priority if (match_reg) begin
                res_status_reg <= STAT_MATCH;
                res_id_reg     <= ID_W'(match_idx_reg);
            end else if (outside) begin
                res_status_reg <= STAT_OUTSIDE;
                res_id_reg     <= ID_NONE;
            end else if (free_found_reg) begin
                res_status_reg <= STAT_NEW;
                res_id_reg     <= ID_W'(free_idx_reg);
            end else begin
                res_status_reg <= STAT_FULL;
                res_id_reg     <= ID_NONE;
            end
        end
        if (load_out) begin
            if (op_reg == FUNC_FEND) begin
                m_status_reg <= STAT_SUMMARY;
                m_id_reg     <= ID_NONE;
                m_cx_reg     <= '0;
                m_cy_reg     <= '0;
                m_rad_reg    <= '0;
                m_cnt_reg    <= det_count_reg;
            end else begin
                m_status_reg <= res_status_reg;
                m_id_reg     <= res_id_reg;
                m_cx_reg     <= cx_reg;
                m_cy_reg     <= cy_reg;
                m_rad_reg    <= rad_reg;
                m_cnt_reg    <= '0;
            end
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {(M_TDATA_W - M_USED_W)'(0), m_cnt_reg, m_rad_reg, m_cy_reg,
                        m_cx_reg, m_id_reg};

    `DMT_ASSERT_IMP(a_match_slot_valid, aclk, aresetn, state_reg == S_WRITE && match_reg, valid_reg[match_idx_reg])
    `DMT_ASSERT_IMP(a_new_slot_free, aclk, aresetn, state_reg == S_WRITE && !match_reg && free_found_reg, !valid_reg[free_idx_reg])
    `DMT_ASSERT_IMP(a_result_from_done, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == S_DONE)

endmodule
